// File: rtl/blse_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// blse_pkg
// Shared types and codes for the bounded list stack engine.
// ----------------------------------------------------------------------------
package blse_pkg;

    localparam int unsigned DepthDefault = 16;

    localparam logic [2:0] OP_PUSH   = 3'd0;
    localparam logic [2:0] OP_POP    = 3'd1;
    localparam logic [2:0] OP_REMOVE = 3'd2;
    localparam logic [2:0] OP_FIND   = 3'd3;
    localparam logic [2:0] OP_CLEAR  = 3'd4;

    localparam logic [1:0] STAT_OK         = 2'd0;
    localparam logic [1:0] STAT_POP_EMPTY  = 2'd1;
    localparam logic [1:0] STAT_PUSH_FULL  = 2'd2;
    localparam logic [1:0] STAT_RM_EMPTY   = 2'd3;

    typedef struct packed {
        logic [2:0]         opcode;
        logic signed [31:0] operand_value;
    } t_in_word;

    typedef struct packed {
        logic               found;
        logic signed [31:0] front_value;
        logic               front_valid;
        logic [4:0]         entry_count;
        logic [1:0]         status;
    } t_out_word;

    typedef enum logic [1:0] {
        SH_HOLD,
        SH_RIGHT,
        SH_LEFT
    } t_shift;

    typedef struct packed {
        t_shift shift;
        logic   load_en;
    } t_chain_ctl;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_RESP
    } t_state;

endpackage
`default_nettype wire

// File: rtl/blse_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// blse_cell
// One list slot: holds a value, takes a neighbor's value on a shift, or
// loads the walked-out front value when it is the write target of a walk step.
// ----------------------------------------------------------------------------
module blse_cell (
    input  wire                 i_clk,
    input  blse_pkg::t_shift    i_shift,
    input  wire                 i_load,
    input  wire signed [31:0]   i_left,
    input  wire signed [31:0]   i_right,
    input  wire signed [31:0]   i_tail,
    output logic signed [31:0]  o_value
);

    logic signed [31:0] r_value;
    logic signed [31:0] n_value;

    always_comb begin
        n_value = r_value;
        if (i_load) begin
            n_value = i_tail;
        end else begin
            case (i_shift)
                blse_pkg::SH_RIGHT: n_value = i_left;
                blse_pkg::SH_LEFT:  n_value = i_right;
                default:            n_value = r_value;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value = r_value;

endmodule
`default_nettype wire

// File: rtl/blse_chain.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// blse_chain
// Row of list cells, front at cell zero. Shifts right on push, left on pop
// and walk steps, and writes the walked-out front value into one cell.
// ----------------------------------------------------------------------------
module blse_chain #(
    parameter int unsigned DEPTH = blse_pkg::DepthDefault,
    localparam int unsigned IW   = $clog2(DEPTH)
) (
    input  wire                     i_clk,
    input  blse_pkg::t_chain_ctl    i_ctl,
    input  wire [IW-1:0]            i_load_idx,
    input  wire signed [31:0]       i_push_value,
    output logic signed [31:0]      o_front
);

    logic signed [31:0] w_val [DEPTH];

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic signed [31:0] w_left;
        logic signed [31:0] w_right;
        logic               w_load;

        if (g == 0) begin : g_first
            assign w_left = i_push_value;
        end else begin : g_mid
            assign w_left = w_val[g-1];
        end

        if (g == DEPTH - 1) begin : g_last
            assign w_right = w_val[g];
        end else begin : g_inner
            assign w_right = w_val[g+1];
        end

        assign w_load = i_ctl.load_en && (i_load_idx == IW'(g));

        blse_cell u_cell (
            .i_clk   (i_clk),
            .i_shift (i_ctl.shift),
            .i_load  (w_load),
            .i_left  (w_left),
            .i_right (w_right),
            .i_tail  (w_val[0]),
            .o_value (w_val[g])
        );
    end

    assign o_front = w_val[0];

endmodule
`default_nettype wire

// File: rtl/bounded_list_stack_engine_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bounded_list_stack_engine_unit
// Bounded front-first list of signed 32-bit values with push, pop, remove,
// find and clear; every command word yields one result word.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (i_in_valid / o_in_ready / i_in_word) takes one command
//   word at a time; o_in_ready is high only while the controller is idle.
//   The output channel (o_out_valid / i_out_ready / o_out_word) returns one
//   result word per command from an output register.
//   Push, pop, clear and unused opcodes go from acceptance straight to the
//   response state, which loads the result register. Remove and find on a
//   non-empty list first walk it through the cell chain, one entry per cycle,
//   visiting every entry (at most DEPTH). Each walk step compares the value at
//   the single front tap of the chain; the walk length is the entry count at
//   acceptance. A new command is accepted in the cycle after the result is
//   registered, while that result may still wait in the output register.
//   If the receiver stalls with a result pending, the next command's result
//   holds in the controller until the output register frees up.
//   Reset empties the list and drops any pending result; cell contents are
//   not cleared and are never shown while the list is empty.
// ----------------------------------------------------------------------------
module bounded_list_stack_engine_unit #(
    parameter int unsigned DEPTH = blse_pkg::DepthDefault
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    output logic                o_in_ready,
    input  blse_pkg::t_in_word  i_in_word,
    output logic                o_out_valid,
    input  wire                 i_out_ready,
    output blse_pkg::t_out_word o_out_word
);

    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam int unsigned IW = $clog2(DEPTH);

    blse_pkg::t_state     r_state, n_state;
    logic [CW-1:0]        r_count, n_count;
    logic [CW-1:0]        r_rem, n_rem;
    logic [CW-1:0]        r_kept, n_kept;
    logic [2:0]           r_op, n_op;
    logic signed [31:0]   r_val, n_val;
    logic                 r_found, n_found;
    logic [1:0]           r_status, n_status;
    logic                 r_out_valid, n_out_valid;
    blse_pkg::t_out_word  r_out, n_out;

    blse_pkg::t_chain_ctl w_ctl;
    logic [IW-1:0]        w_load_idx;
    logic [CW-1:0]        w_tail_pos;
    logic [CW-1:0]        w_kept_next;
    logic signed [31:0]   w_front;
    logic                 w_match;
    logic                 w_accept;
    blse_pkg::t_out_word  w_resp;

    blse_chain #(
        .DEPTH (DEPTH)
    ) u_chain (
        .i_clk        (i_clk),
        .i_ctl        (w_ctl),
        .i_load_idx   (w_load_idx),
        .i_push_value (i_in_word.operand_value),
        .o_front      (w_front)
    );

    assign o_in_ready  = (r_state == blse_pkg::ST_IDLE);
    assign w_accept    = i_in_valid && o_in_ready;
    assign w_match     = (w_front == r_val);
    assign w_kept_next = r_kept + CW'(!w_match);
    // Unprocessed entries sit below the kept ones, so the next kept entry
    // lands just after both groups once the chain has shifted left.
    assign w_tail_pos  = r_rem - CW'(1) + r_kept;

    always_comb begin
        w_resp.found       = r_found;
        w_resp.front_valid = (r_count != '0);
        w_resp.front_value = (r_count != '0) ? w_front : 32'sd0;
        w_resp.entry_count = 5'(r_count);
        w_resp.status      = r_status;
    end

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_rem       = r_rem;
        n_kept      = r_kept;
        n_op        = r_op;
        n_val       = r_val;
        n_found     = r_found;
        n_status    = r_status;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_out_ready;
        w_ctl.shift   = blse_pkg::SH_HOLD;
        w_ctl.load_en = 1'b0;
        w_load_idx    = '0;

        unique case (r_state)
            blse_pkg::ST_IDLE: begin
                if (w_accept) begin
                    n_op     = i_in_word.opcode;
                    n_val    = i_in_word.operand_value;
                    n_found  = 1'b0;
                    n_status = blse_pkg::STAT_OK;
                    n_kept   = '0;
                    n_rem    = r_count;
                    n_state  = blse_pkg::ST_RESP;
                    unique case (i_in_word.opcode)
                        blse_pkg::OP_PUSH: begin
                            if (r_count == CW'(DEPTH)) begin
                                n_status = blse_pkg::STAT_PUSH_FULL;
                            end else begin
                                w_ctl.shift = blse_pkg::SH_RIGHT;
                                n_count     = r_count + CW'(1);
                            end
                        end
                        blse_pkg::OP_POP: begin
                            if (r_count == '0) begin
                                n_status = blse_pkg::STAT_POP_EMPTY;
                            end else begin
                                w_ctl.shift = blse_pkg::SH_LEFT;
                                n_count     = r_count - CW'(1);
                            end
                        end
                        blse_pkg::OP_REMOVE: begin
                            if (r_count == '0) begin
                                n_status = blse_pkg::STAT_RM_EMPTY;
                            end else begin
                                n_state = blse_pkg::ST_WALK;
                            end
                        end
                        blse_pkg::OP_FIND: begin
                            if (r_count != '0) begin
                                n_state = blse_pkg::ST_WALK;
                            end
                        end
                        blse_pkg::OP_CLEAR: begin
                            n_count = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            blse_pkg::ST_WALK: begin
                w_ctl.shift = blse_pkg::SH_LEFT;
                n_rem       = r_rem - CW'(1);
                if (r_op == blse_pkg::OP_REMOVE) begin
                    w_ctl.load_en = !w_match;
                    w_load_idx    = w_tail_pos[IW-1:0];
                    n_kept        = w_kept_next;
                end else begin
                    // Find rotates every entry to the tail, restoring order.
                    w_ctl.load_en = 1'b1;
                    w_load_idx    = IW'(r_count - CW'(1));
                    n_found       = r_found || w_match;
                end
                if (r_rem == CW'(1)) begin
                    n_state = blse_pkg::ST_RESP;
                    if (r_op == blse_pkg::OP_REMOVE) begin
                        n_count = w_kept_next;
                        if (w_kept_next == '0) begin
                            n_status = blse_pkg::STAT_RM_EMPTY;
                        end
                    end
                end
            end
            blse_pkg::ST_RESP: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out       = w_resp;
                    n_out_valid = 1'b1;
                    n_state     = blse_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = blse_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= blse_pkg::ST_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem    <= n_rem;
        r_kept   <= n_kept;
        r_op     <= n_op;
        r_val    <= n_val;
        r_found  <= n_found;
        r_status <= n_status;
        r_out    <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("entry count exceeds list depth");

    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && (i_in_word.opcode == blse_pkg::OP_PUSH) && (r_count < CW'(DEPTH))
        |=> r_count == $past(r_count) + CW'(1))
        else $error("push did not add an entry");

    a_walk_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == blse_pkg::ST_WALK) |-> (r_rem != '0))
        else $error("walk running with no entries left");

    a_walk_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == blse_pkg::ST_WALK) |-> ((r_rem + r_kept) <= r_count))
        else $error("walk pointers run past the list");

    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == blse_pkg::ST_RESP))
        else $error("result word appeared outside the response state");

endmodule
`default_nettype wire
